// ----- rtl/mmm_pkg.sv -----
`timescale 1ns / 1ps

package mmm_pkg;

    localparam int WORD_BITS     = 32;
    localparam int ACC_BITS      = 2 * WORD_BITS;
    localparam int OPER_BITS     = 31;
    localparam int DIGIT_BITS    = 8;
    localparam int CELLS_PER_MUL = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NUM_MULS      = 3;
    localparam int NUM_CELLS     = NUM_MULS * CELLS_PER_MUL;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [1:0] MODE_MUL      = 2'd0;
    localparam logic [1:0] MODE_TO_MONT  = 2'd1;
    localparam logic [1:0] MODE_FROM_MONT = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_INV   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_R_SQUARED = 2'd2;

    // one word in flight through the multiplier row
    typedef struct packed {
        logic                  err;
        logic [ACC_BITS-1:0]   x;
        logic [ACC_BITS-1:0]   mcand;
        logic [WORD_BITS-1:0]  mplier;
        logic [ACC_BITS-1:0]   acc;
    } mmm_lane_t;

endpackage

// ----- rtl/montgomery_modular_multiplier_top.sv -----
`timescale 1ns / 1ps

// Montgomery modular multiplier, R = 2^32, odd modulus below 2^31.
// Input words: s_tuser holds the mode (0 multiply, 1 convert into the
// domain, 2 convert out), s_tdata holds operand_a and operand_b.
// Output words: m_tdata holds the reduced result, m_tuser flags an
// operand not below the modulus or mode 3 (result then reads zero).
// The modulus, its inverse mod 2^32 and R^2 mod m are set through the
// cfg write port; the user must do so only while no word is in flight,
// the block itself does not enforce it. A row of 12 multiplier cells,
// one 8-bit digit each (four for a*b, four for the low word times the
// inverse, four for modulus times that value), feeds a subtract stage
// and an output stage. Throughput is one word per cycle; every cell
// hands its word on each cycle it is not blocked by the cell after it.
// Reset empties every stage and loads modulus 1, inverse 1, R^2 0.
// When the receiver stalls, words pile up in the row; s_tready drops
// only once the first cell holds a word that cannot move on.
module montgomery_modular_multiplier_top import mmm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [63:0]              s_tdata,   // operand_a, operand_b, zero pad
    input  logic [1:0]               s_tuser,   // mode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,   // result, zero pad
    output logic                     m_tuser    // operand_error
);

    logic [OPER_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] mod_inv_reg;
    logic [OPER_BITS-1:0] r_squared_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= OPER_BITS'(1);
            mod_inv_reg   <= WORD_BITS'(1);
            r_squared_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODULUS:   modulus_reg   <= cfg_wdata[OPER_BITS-1:0];
                CFG_MOD_INV:   mod_inv_reg   <= cfg_wdata[WORD_BITS-1:0];
                CFG_R_SQUARED: r_squared_reg <= cfg_wdata[OPER_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [OPER_BITS-1:0] op_a;
    logic [OPER_BITS-1:0] op_b;
    mmm_lane_t            first_lane;

    assign op_a = s_tdata[OPER_BITS-1:0];
    assign op_b = s_tdata[2*OPER_BITS-1:OPER_BITS];

    always_comb begin
        first_lane       = '0;
        first_lane.mcand = {{(ACC_BITS-OPER_BITS){1'b0}}, op_a};
        case (s_tuser)
            MODE_MUL: begin
                first_lane.err    = (op_a >= modulus_reg) || (op_b >= modulus_reg);
                first_lane.mplier = {{(WORD_BITS-OPER_BITS){1'b0}}, op_b};
            end
            MODE_TO_MONT: begin
                first_lane.err    = (op_a >= modulus_reg);
                first_lane.mplier = {{(WORD_BITS-OPER_BITS){1'b0}}, r_squared_reg};
            end
            MODE_FROM_MONT: begin
                first_lane.err    = (op_a >= modulus_reg);
                first_lane.mplier = WORD_BITS'(1);
            end
            default: begin
                first_lane.err    = 1'b1;
                first_lane.mplier = '0;
            end
        endcase
    end

    mmm_lane_t lane_in  [NUM_CELLS];
    mmm_lane_t lane_out [NUM_CELLS];
    logic      cell_in_valid [NUM_CELLS];
    logic      cell_in_ready [NUM_CELLS];
    logic      cell_valid    [NUM_CELLS];
    logic      cell_down_rdy [NUM_CELLS];
    logic      fin_ready;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_row
        if (i == 0) begin : g_head
            assign lane_in[i]       = first_lane;
            assign cell_in_valid[i] = s_tvalid;
        end else if (i == CELLS_PER_MUL) begin : g_inv
            // product done: multiply its low word by the inverse
            always_comb begin
                lane_in[i]        = lane_out[i-1];
                lane_in[i].x      = lane_out[i-1].acc;
                lane_in[i].mcand  = {{(ACC_BITS-WORD_BITS){1'b0}},
                                     lane_out[i-1].acc[WORD_BITS-1:0]};
                lane_in[i].mplier = mod_inv_reg;
                lane_in[i].acc    = '0;
            end
            assign cell_in_valid[i] = cell_valid[i-1];
        end else if (i == 2 * CELLS_PER_MUL) begin : g_mod
            // low word of that product is u, now form modulus times u
            always_comb begin
                lane_in[i]        = lane_out[i-1];
                lane_in[i].mcand  = {{(ACC_BITS-OPER_BITS){1'b0}}, modulus_reg};
                lane_in[i].mplier = lane_out[i-1].acc[WORD_BITS-1:0];
                lane_in[i].acc    = '0;
            end
            assign cell_in_valid[i] = cell_valid[i-1];
        end else begin : g_pass
            assign lane_in[i]       = lane_out[i-1];
            assign cell_in_valid[i] = cell_valid[i-1];
        end

        if (i == NUM_CELLS - 1) begin : g_tail
            assign cell_down_rdy[i] = fin_ready;
        end else begin : g_link
            assign cell_down_rdy[i] = cell_in_ready[i+1];
        end

        mmm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_in_valid[i]),
            .in_ready  (cell_in_ready[i]),
            .in_lane   (lane_in[i]),
            .out_valid (cell_valid[i]),
            .out_ready (cell_down_rdy[i]),
            .out_lane  (lane_out[i])
        );
    end

    assign s_tready = cell_in_ready[0];

    logic [OPER_BITS-1:0] result;

    mmm_final u_final (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (cell_valid[NUM_CELLS-1]),
        .in_ready      (fin_ready),
        .in_lane       (lane_out[NUM_CELLS-1]),
        .modulus       (modulus_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .result        (result),
        .operand_error (m_tuser)
    );

    assign m_tdata = {{(32-OPER_BITS){1'b0}}, result};

    // an errored word always carries a zero result
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("errored word with nonzero result");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // input backpressure only when the first cell is occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> cell_valid[0])
        else $error("input stalled with empty first cell");

    // a word taken at the input reaches the first cell
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cell_valid[0])
        else $error("accepted word lost at first cell");

endmodule

// ----- rtl/mmm_cell.sv -----
`timescale 1ns / 1ps

module mmm_cell import mmm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  mmm_lane_t in_lane,
    output logic      out_valid,
    input  logic      out_ready,
    output mmm_lane_t out_lane
);

    logic                           valid_reg;
    mmm_lane_t                      lane_reg;
    mmm_lane_t                      lane_next;
    logic [ACC_BITS+DIGIT_BITS-1:0] prod;

    // one digit of the multiplier per cell, multiplicand moves up a digit
    always_comb begin
        prod             = in_lane.mcand * in_lane.mplier[DIGIT_BITS-1:0];
        lane_next        = in_lane;
        lane_next.acc    = in_lane.acc + prod[ACC_BITS-1:0];
        lane_next.mcand  = in_lane.mcand << DIGIT_BITS;
        lane_next.mplier = in_lane.mplier >> DIGIT_BITS;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lane_reg <= lane_next;
        end
    end

endmodule

// ----- rtl/mmm_final.sv -----
`timescale 1ns / 1ps

module mmm_final import mmm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mmm_lane_t            in_lane,
    input  logic [OPER_BITS-1:0] modulus,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OPER_BITS-1:0] result,
    output logic                 operand_error
);

    logic                      diff_valid_reg;
    logic                      diff_err_reg;
    logic [ACC_BITS-1:0]       diff_reg;
    logic                      diff_ready;
    logic                      res_valid_reg;
    logic [OPER_BITS-1:0]      res_reg;
    logic                      res_err_reg;
    logic [WORD_BITS-1:0]      quot;
    logic [WORD_BITS-1:0]      corr;
    logic [WORD_BITS-1:0]      ans;

    assign diff_ready = !res_valid_reg || out_ready;
    assign in_ready   = !diff_valid_reg || diff_ready;

    // floor shift of the difference, modulus added back once if negative
    always_comb begin
        quot = diff_reg[ACC_BITS-1:WORD_BITS];
        corr = diff_reg[ACC_BITS-1] ? {{(WORD_BITS-OPER_BITS){1'b0}}, modulus}
                                    : '0;
        ans  = quot + corr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                diff_valid_reg <= in_valid;
            end
            if (diff_ready) begin
                res_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            diff_reg     <= in_lane.x - in_lane.acc;
            diff_err_reg <= in_lane.err;
        end
        if (diff_ready && diff_valid_reg) begin
            res_reg     <= diff_err_reg ? '0 : ans[OPER_BITS-1:0];
            res_err_reg <= diff_err_reg;
        end
    end

    assign out_valid     = res_valid_reg;
    assign result        = res_reg;
    assign operand_error = res_err_reg;

endmodule

// ----- dv/montgomery_modular_multiplier_top_tb.sv -----
`timescale 1ns / 1ps

module montgomery_modular_multiplier_top_tb;
    import mmm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [30:0] MOD_MAX    = 31'h7FFF_FFFF;

    typedef struct {
        logic [1:0]  mode;
        logic [30:0] a;
        logic [30:0] b;
    } mul_req_t;

    typedef struct {
        logic [30:0] result;
        logic        err;
    } mul_resp_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [63:0]              s_tdata = '0;
    logic [1:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [31:0]              m_tdata;
    logic                     m_tuser;

    // predictor copy of the registers
    logic [30:0] cur_mod = 31'd1;
    logic [31:0] cur_inv = 32'd1;
    logic [30:0] cur_r2  = 31'd0;

    mul_req_t  pending[$];
    mul_resp_t products[$];
    mul_req_t  drive_item;

    bit calm = 1'b0;
    bit in_taken = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int accepted_cnt = 0;
    int items_queued = 0;
    int results_seen = 0;
    int mism = 0;

    montgomery_modular_multiplier_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // x * R^-1 mod m with R = 2^32, floor division of x - m*u
    function automatic logic [30:0] mont_fold(input logic [63:0] x);
        logic [31:0]        u;
        logic signed [63:0] d;
        logic signed [63:0] q;
        u = x[31:0] * cur_inv;
        d = $signed(x - (64'(cur_mod) * 64'(u)));
        q = d >>> 32;
        if (q < 0) begin
            q = q + $signed(64'(cur_mod));
        end
        return q[30:0];
    endfunction

    function automatic mul_resp_t predict_product(input logic [1:0] mode,
                                                  input logic [30:0] a,
                                                  input logic [30:0] b);
        mul_resp_t r;
        r.result = '0;
        case (mode)
            MODE_MUL: begin
                r.err = (a >= cur_mod) || (b >= cur_mod);
                if (!r.err) r.result = mont_fold(64'(a) * 64'(b));
            end
            MODE_TO_MONT: begin
                r.err = (a >= cur_mod);
                if (!r.err) r.result = mont_fold(64'(a) * 64'(cur_r2));
            end
            MODE_FROM_MONT: begin
                r.err = (a >= cur_mod);
                if (!r.err) r.result = mont_fold(64'(a));
            end
            default: r.err = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] inverse_of(input logic [30:0] m);
        logic [31:0] y;
        logic [31:0] mm;
        mm = 32'(m);
        y = mm;
        repeat (5) y = y * (32'd2 - mm * y);
        return y;
    endfunction

    function automatic logic [30:0] r2_of(input logic [30:0] m);
        logic [64:0] p;
        p = (65'd1 << 64) % 65'(m);
        return p[30:0];
    endfunction

    task automatic queue_item(input logic [1:0] mode, input logic [30:0] a,
                              input logic [30:0] b);
        pending.push_back('{mode, a, b});
        items_queued++;
    endtask

    task automatic add_random(input int n);
        mul_req_t r;
        int       pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (cur_mod != 0 && pick < 85) begin
                r.mode = 2'($urandom_range(2));
                r.a = (pick < 6) ? cur_mod - 31'd1 : 31'($urandom % cur_mod);
                if (r.mode == MODE_MUL)
                    r.b = (pick < 3) ? cur_mod - 31'd1 : 31'($urandom % cur_mod);
                else
                    r.b = 31'($urandom);
            end else begin
                r.mode = 2'($urandom_range(3));
                r.a = 31'($urandom);
                r.b = 31'($urandom);
            end
            queue_item(r.mode, r.a, r.b);
        end
    endtask

    // every queued word has come back once the counts meet
    task automatic wait_idle();
        @(negedge aclk);
        while (results_seen != items_queued) @(negedge aclk);
    endtask

    task automatic set_config(input logic [30:0] m, input logic [31:0] inv,
                              input logic [30:0] r2);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODULUS;
        cfg_wdata <= 32'(m);
        @(negedge aclk);
        cfg_index <= CFG_MOD_INV;
        cfg_wdata <= inv;
        @(negedge aclk);
        cfg_index <= CFG_R_SQUARED;
        cfg_wdata <= 32'(r2);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mod = m;
        cur_inv = inv;
        cur_r2  = r2;
        @(posedge aclk);
    endtask

    task automatic report(input string what, input mul_resp_t e);
        mism++;
        if (mism <= 10)
            $display("mismatch (%s): expected result %h err %b, got result %h err %b",
                     what, e.result, e.err, m_tdata[30:0], m_tuser);
    endtask

    // sender: holds a word until taken, idles at random otherwise
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (pending.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
                drive_item = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drive_item.mode;
                s_tdata  <= {2'b00, drive_item.b, drive_item.a};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the row up
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= 700) begin
            m_tready  <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge aclk) begin
        mul_resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (products.size() == 0) begin
                e = '{'0, 1'b0};
                report("unexpected word", e);
            end else begin
                e = products.pop_front();
                if (m_tdata[30:0] !== e.result || m_tuser !== e.err)
                    report("field", e);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            products.push_back(predict_product(s_tuser, s_tdata[30:0], s_tdata[61:31]));
            accepted_cnt++;
            in_taken = 1'b1;
        end else begin
            in_taken = 1'b0;
        end
    end

    initial begin
        logic [30:0] m;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: modulus 1, only zero operands are in range
        queue_item(MODE_MUL, 31'd0, 31'd0);
        queue_item(MODE_TO_MONT, 31'd0, 31'd0);
        queue_item(MODE_FROM_MONT, 31'd0, MOD_MAX);
        queue_item(MODE_MUL, 31'd1, 31'd0);
        queue_item(MODE_UNUSED, 31'd0, 31'd0);
        add_random(50);

        // largest modulus, no idling on either side
        set_config(MOD_MAX, inverse_of(MOD_MAX), r2_of(MOD_MAX));
        calm = 1'b1;
        queue_item(MODE_MUL, 31'd0, 31'd0);
        queue_item(MODE_MUL, MOD_MAX - 31'd1, MOD_MAX - 31'd1);
        queue_item(MODE_MUL, 31'd1, 31'd1);
        queue_item(MODE_MUL, MOD_MAX - 31'd1, 31'd1);
        queue_item(MODE_TO_MONT, 31'd0, 31'd0);
        queue_item(MODE_TO_MONT, MOD_MAX - 31'd1, MOD_MAX);
        queue_item(MODE_FROM_MONT, MOD_MAX - 31'd1, 31'd0);
        queue_item(MODE_FROM_MONT, 31'd1, MOD_MAX);
        queue_item(MODE_MUL, MOD_MAX, 31'd0);
        queue_item(MODE_MUL, 31'd0, MOD_MAX);
        queue_item(MODE_TO_MONT, MOD_MAX, 31'd0);
        queue_item(MODE_FROM_MONT, MOD_MAX, 31'd0);
        queue_item(MODE_UNUSED, 31'd0, 31'd0);
        queue_item(MODE_UNUSED, MOD_MAX, MOD_MAX);
        add_random(400);

        // zero modulus: every operand is out of range
        set_config(31'd0, 32'd0, 31'd0);
        calm = 1'b0;
        queue_item(MODE_MUL, 31'd0, 31'd0);
        queue_item(MODE_TO_MONT, 31'd0, 31'd0);
        queue_item(MODE_FROM_MONT, 31'd0, 31'd0);
        add_random(50);

        set_config(31'd3, inverse_of(31'd3), r2_of(31'd3));
        add_random(150);

        m = 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000)) | 31'd1;
        set_config(m, inverse_of(m), r2_of(m));
        add_random(450);

        m = 31'($urandom_range(1000, 5)) | 31'd1;
        set_config(m, inverse_of(m), r2_of(m));
        add_random(200);

        // inconsistent inverse and r_squared: same datapath, the DUT does not check them
        m = 31'($urandom_range(32'h7FFF_FFFF, 32'h100)) | 31'd1;
        set_config(m, $urandom, 31'($urandom_range(2147483646)));
        add_random(200);

        m = 31'($urandom_range(2147483646, 2)) & ~31'd1;
        set_config(m, 32'hFFFF_FFFF, 31'd2147483646);
        add_random(150);

        set_config(31'd1, 32'hFFFF_FFFF, 31'd2147483646);
        add_random(50);

        wait_idle();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (mism == 0 && products.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mmm_pkg.sv
rtl/mmm_cell.sv
rtl/mmm_final.sv
rtl/montgomery_modular_multiplier_top.sv
dv/montgomery_modular_multiplier_top_tb.sv
